FILE: rtl/sbpt_pkg.sv
package sbpt_pkg;

  // Fixed widths of the fields and registers
  localparam int FREQ_W    = 32;
  localparam int MAG_W     = 32;
  localparam int CH_W      = 2;
  localparam int BANDS     = 3;
  localparam int REG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int IN_DATA_W = 32;
  // channel, peak_freq and peak_mag packed, padded to whole bytes
  localparam int OUT_USED_W = CH_W + FREQ_W + MAG_W;
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

  localparam logic [FREQ_W-1:0] BIN_STEP_RESET = FREQ_W'(256);

  // Configuration register indices
  typedef enum logic [REG_IDX_W-1:0] {
    REG_BIN_STEP   = 3'd0,
    REG_BAND0_LOW  = 3'd1,
    REG_BAND0_HIGH = 3'd2,
    REG_BAND1_LOW  = 3'd3,
    REG_BAND1_HIGH = 3'd4,
    REG_BAND2_LOW  = 3'd5,
    REG_BAND2_HIGH = 3'd6
  } reg_idx_t;

  // Peak of one channel
  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [MAG_W-1:0]  mag;
  } peak_t;

  // True when f lies in [lo - res, hi + res]; the low bound floors at zero
  // and the high bound is compared one bit wider so that it cannot wrap.
  function automatic logic in_widened(input logic [FREQ_W-1:0] f,
                                      input logic [FREQ_W-1:0] lo,
                                      input logic [FREQ_W-1:0] hi,
                                      input logic [FREQ_W-1:0] res);
    logic [FREQ_W-1:0] lo_w;
    logic [FREQ_W:0]   hi_w;
    lo_w = (lo > res) ? (lo - res) : '0;
    hi_w = {1'b0, hi} + {1'b0, res};
    return (f >= lo_w) && ({1'b0, f} <= hi_w);
  endfunction

endpackage

FILE: rtl/sbpt_tracker.sv
module sbpt_tracker import sbpt_pkg::*; #(
  parameter int CHANNELS = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [MAG_W-1:0]  magnitude,
  input  logic              last_bin,
  input  logic [FREQ_W-1:0] bin_step,
  input  logic [FREQ_W-1:0] band_low  [BANDS],
  input  logic [FREQ_W-1:0] band_high [BANDS],
  output peak_t             peak      [CHANNELS]
);

  localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

  logic [FREQ_W-1:0] bin_freq;
  logic [CH_W-1:0]   active_channel;
  logic              finished;
  peak_t             best [CHANNELS];

  logic [CH_W-1:0]   ch;
  logic [CH_W-1:0]   ch_up;
  logic              considered;
  logic              in_cur;
  logic              in_up;
  logic              finish_hit;
  logic              move;
  logic [FREQ_W:0]   freq_sum;
  logic [FREQ_W-1:0] bin_freq_next;

  // Channel selection and range tests for the current bin
  always_comb begin
    ch         = (active_channel > LAST_CH) ? LAST_CH : active_channel;
    ch_up      = (ch == LAST_CH) ? ch : ch + 1'b1;
    considered = !finished && (bin_freq >= band_low[0]);
    in_cur     = in_widened(bin_freq, band_low[ch], band_high[ch], bin_step);
    in_up      = in_widened(bin_freq, band_low[ch_up], band_high[ch_up], bin_step);
    finish_hit = considered && !in_cur && (ch == LAST_CH);
    move       = considered && !in_cur && (ch != LAST_CH) && in_up;
  end

  // One compare lane per channel; only the active channel can take the bin.
  always_comb begin
    for (int k = 0; k < CHANNELS; k++) begin
      if (considered && in_cur && (ch == CH_W'(k)) && (magnitude > best[k].mag)) begin
        peak[k] = '{freq: bin_freq, mag: magnitude};
      end else begin
        peak[k] = best[k];
      end
    end
  end

  // Bin frequency advances by the resolution and saturates.
  always_comb begin
    freq_sum      = {1'b0, bin_freq} + {1'b0, bin_step};
    bin_freq_next = freq_sum[FREQ_W] ? '1 : freq_sum[FREQ_W-1:0];
  end

  // Tracking state; the last bin of a frame clears it.
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_freq       <= '0;
      active_channel <= '0;
      finished       <= 1'b0;
      for (int k = 0; k < CHANNELS; k++) begin
        best[k] <= '0;
      end
    end else if (accept) begin
      if (last_bin) begin
        bin_freq       <= '0;
        active_channel <= '0;
        finished       <= 1'b0;
        for (int k = 0; k < CHANNELS; k++) begin
          best[k] <= '0;
        end
      end else begin
        bin_freq <= bin_freq_next;
        if (finish_hit) begin
          finished <= 1'b1;
        end
        if (move) begin
          active_channel <= ch_up;
        end
        for (int k = 0; k < CHANNELS; k++) begin
          best[k] <= peak[k];
        end
      end
    end
  end

endmodule

FILE: rtl/spectral_band_peak_tracker.sv
// An accepted last bin makes its first report valid in the next cycle; other bins only update state.
// Throughput: one bin per cycle; the last bin of a frame starts CHANNELS reports,
// one per cycle while m_axis_tready is high, from a snapshot buffer, while bins of the next frame keep flowing.
// A last bin is held off only while the previous frame's reports are still queued.
// Reset (rst, synchronous): clears tracking state and queued reports;
// the bin step returns to 256 and all band bounds to zero.
module spectral_band_peak_tracker import sbpt_pkg::*; #(
  parameter int CHANNELS = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [31:0] magnitude
  input  logic                  s_axis_tlast,   // last_bin
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [1:0] channel, [33:2] peak_freq,
                                                // [65:34] peak_mag, rest zero
  output logic                  m_axis_tlast    // last_report
);

  localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

  logic [FREQ_W-1:0] bin_step;
  logic [FREQ_W-1:0] band_low  [BANDS];
  logic [FREQ_W-1:0] band_high [BANDS];

  logic              s_acc;
  logic              m_acc;
  logic              pend;
  logic [CH_W-1:0]   rep_idx;
  peak_t             peak [CHANNELS];
  peak_t             snap [CHANNELS];
  peak_t             sel;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_step <= BIN_STEP_RESET;
      for (int k = 0; k < BANDS; k++) begin
        band_low[k]  <= '0;
        band_high[k] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BIN_STEP:   bin_step     <= cfg_data;
        REG_BAND0_LOW:  band_low[0]  <= cfg_data;
        REG_BAND0_HIGH: band_high[0] <= cfg_data;
        REG_BAND1_LOW:  band_low[1]  <= cfg_data;
        REG_BAND1_HIGH: band_high[1] <= cfg_data;
        REG_BAND2_LOW:  band_low[2]  <= cfg_data;
        REG_BAND2_HIGH: band_high[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input handshake: a last bin waits until the previous reports have gone.
  assign s_axis_tready = !pend || !s_axis_tlast;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_acc         = m_axis_tvalid && m_axis_tready;

  sbpt_tracker #(
    .CHANNELS (CHANNELS)
  ) u_tracker (
    .clk       (clk),
    .rst       (rst),
    .accept    (s_acc),
    .magnitude (s_axis_tdata[MAG_W-1:0]),
    .last_bin  (s_axis_tlast),
    .bin_step  (bin_step),
    .band_low  (band_low),
    .band_high (band_high),
    .peak      (peak)
  );

  // Snapshot of the peaks, including the last bin itself
  always_ff @(posedge clk) begin
    if (s_acc && s_axis_tlast) begin
      for (int k = 0; k < CHANNELS; k++) begin
        snap[k] <= peak[k];
      end
    end
  end

  // Report sequencer: one channel per accepted item on the output side
  always_ff @(posedge clk) begin
    if (rst) begin
      pend    <= 1'b0;
      rep_idx <= '0;
    end else begin
      if (m_acc) begin
        if (rep_idx == LAST_CH) begin
          pend    <= 1'b0;
          rep_idx <= '0;
        end else begin
          rep_idx <= rep_idx + 1'b1;
        end
      end
      if (s_acc && s_axis_tlast) begin
        pend    <= 1'b1;
        rep_idx <= '0;
      end
    end
  end

  // Select the channel being reported.
  always_comb begin
    sel = '0;
    for (int k = 0; k < CHANNELS; k++) begin
      if (rep_idx == CH_W'(k)) begin
        sel = snap[k];
      end
    end
  end

  assign m_axis_tvalid = pend;
  assign m_axis_tlast  = (rep_idx == LAST_CH);
  assign m_axis_tdata  = {{(OUT_DATA_W - OUT_USED_W){1'b0}}, sel.mag, sel.freq, rep_idx};

  // A last bin is never taken while reports are still queued.
  assert property (@(posedge clk) disable iff (rst)
    !(s_acc && s_axis_tlast && pend))
    else $error("last bin accepted while reports pending");

  // A frame end always starts a report run with the first channel.
  assert property (@(posedge clk) disable iff (rst)
    (s_acc && s_axis_tlast) |=> (m_axis_tvalid && (m_axis_tdata[CH_W-1:0] == '0)))
    else $error("frame end did not start reports");

  // The reported channel stays within range.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[CH_W-1:0] <= LAST_CH))
    else $error("report channel out of range");

  // After the final report is taken the run is over.
  assert property (@(posedge clk) disable iff (rst)
    (m_acc && m_axis_tlast && !(s_acc && s_axis_tlast)) |=> !m_axis_tvalid)
    else $error("reports continue past the final channel");

endmodule
